// ===== hw/rtl/laplace_interval_encode_unit_defines.svh =====
// Assertion helpers shared by the Laplace interval encoder.
// Every check samples on i_clk and is masked while i_rst_n is low.
`ifndef LAPLACE_INTERVAL_ENCODE_UNIT_DEFINES_SVH
`define LAPLACE_INTERVAL_ENCODE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LIE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LIE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lie_pkg.sv =====
package lie_pkg;

    localparam int unsigned TOTAL    = 32768;
    localparam int unsigned ONE_Q14  = 16384;
    localparam int unsigned Q_SHIFT  = 14;
    localparam int unsigned LOW_W    = 15;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned DECAY_W  = 14;
    localparam int unsigned FREQ_W   = 16;
    localparam int unsigned MAG_W    = VALUE_W + 1;
    localparam int unsigned FL_W     = 17;
    localparam int unsigned NUM_W    = DECAY_W + 1 + LOW_W;
    localparam int unsigned DEN_W    = DECAY_W + 1;
    localparam int unsigned DIV_STEPS = FREQ_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_LOAD,
        ST_MUL,
        ST_STEP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_en;
        logic step_en;
    } t_walk_ctl;

    typedef struct packed {
        logic at_mag;
        logic fits;
    } t_walk_sts;

endpackage

// ===== hw/rtl/lie_div.sv =====
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// FREQ_W bits, i.e. the numerator's upper bits start below the divisor.
module lie_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lie_pkg::NUM_W-1:0]     i_num,
    input  logic [lie_pkg::DEN_W-1:0]     i_den,
    output logic                          o_done,
    output logic [lie_pkg::FREQ_W-1:0]    o_quot
);

    localparam int unsigned RW = lie_pkg::DEN_W;
    localparam int unsigned QW = lie_pkg::FREQ_W;

    logic                            r_busy;
    logic                            r_done;
    logic [lie_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [RW-1:0]                   r_rem;
    logic [QW-1:0]                   r_num;
    logic [QW-1:0]                   r_quot;
    logic [RW:0]                     w_trial;
    logic                            w_ge;
    logic [RW:0]                     w_diff;

    assign w_trial = {r_rem, r_num[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, i_den});
    assign w_diff  = w_trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == lie_pkg::DIV_CNT_W'(lie_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= RW'(i_num[lie_pkg::NUM_W-1:QW]);
            r_num  <= i_num[QW-1:0];
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
            r_num  <= {r_num[QW-2:0], 1'b0};
            r_quot <= {r_quot[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/lie_walk.sv =====
// Interval walk: one shared multiplier scales the slot size, two adders and a
// compare check that the next pair still fits the table.
module lie_walk (
    input  logic                          i_clk,
    input  lie_pkg::t_walk_ctl            i_ctl,
    input  logic [lie_pkg::FREQ_W-1:0]    i_fs0,
    input  logic [lie_pkg::MAG_W-1:0]     i_mag,
    input  logic [lie_pkg::DECAY_W-1:0]   i_decay,
    output lie_pkg::t_walk_sts            o_sts,
    output logic [lie_pkg::FREQ_W-1:0]    o_fl,
    output logic [lie_pkg::FREQ_W-1:0]    o_fs,
    output logic [lie_pkg::FREQ_W-1:0]    o_steps
);

    localparam int unsigned FW = lie_pkg::FREQ_W;
    localparam int unsigned PW = lie_pkg::FREQ_W + lie_pkg::DECAY_W;

    logic signed [lie_pkg::FL_W-1:0]  r_fl;
    logic [FW-1:0]                    r_fs;
    logic [FW-1:0]                    r_nfs;
    logic [FW-1:0]                    r_steps;
    logic [PW-1:0]                    w_prod;
    logic [FW-1:0]                    w_scaled;
    logic signed [lie_pkg::FL_W:0]    w_nfl;
    logic signed [lie_pkg::FL_W+1:0]  w_end;

    assign w_prod   = r_fs * i_decay;
    assign w_scaled = w_prod[PW-1:lie_pkg::Q_SHIFT];

    // Next pair start and its end.
    assign w_nfl = $signed({r_fl[lie_pkg::FL_W-1], r_fl}) + $signed({1'b0, r_fs, 1'b0});
    assign w_end = $signed({w_nfl[lie_pkg::FL_W], w_nfl}) + $signed({2'b00, r_nfs, 1'b0});

    assign o_sts.at_mag = ({1'b0, r_steps} == i_mag);
    assign o_sts.fits   = (w_end <= $signed((lie_pkg::FL_W+2)'(lie_pkg::TOTAL)));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_fs    <= i_fs0;
            r_fl    <= -$signed({1'b0, i_fs0});
            r_steps <= '0;
        end else if (i_ctl.mul_en) begin
            // floor the slot at 1
            r_nfs <= (w_scaled == '0) ? FW'(1) : w_scaled;
        end else if (i_ctl.step_en && o_sts.fits) begin
            r_fl    <= w_nfl[lie_pkg::FL_W-1:0];
            r_fs    <= r_nfs;
            r_steps <= r_steps + 1'b1;
        end
    end

    assign o_fl    = r_fl[FW-1:0];
    assign o_fs    = r_fs;
    assign o_steps = r_steps;

endmodule

// ===== hw/rtl/laplace_interval_encode_unit.sv =====
// Sequence: capture the item, derive the start frequency in the divider unless a given start
//   is used (one quotient bit per cycle), load the walk, step it until the magnitude is reached
//   or a full table stops it, then register the result; a stalled result holds the sequencer.
// Throughput: one item at a time; each magnitude step uses the shared multiplier and
//   the fit adders in turn, so the walk length sets the rate.
// Reset: synchronous, active low; clears the sequencer and the output valid.
`include "laplace_interval_encode_unit_defines.svh"

module laplace_interval_encode_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] value, [29:16] decay, [45:30] start_freq, [47:46] zero
    input  logic [47:0] s_axis_tdata,
    // [0] use_given_start
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [14:0] interval_low, [30:15] interval_high, [46:31] coded_value, [47] zero
    output logic [47:0] m_axis_tdata,
    // [0] was_clamped
    output logic        m_axis_tuser
);

    localparam int unsigned FW = lie_pkg::FREQ_W;
    localparam int unsigned LW = lie_pkg::LOW_W;
    localparam int unsigned MW = lie_pkg::MAG_W;
    localparam int unsigned DW = lie_pkg::DECAY_W;

    lie_pkg::t_state    r_state;
    lie_pkg::t_state    n_state;
    lie_pkg::t_walk_ctl w_ctl;
    lie_pkg::t_walk_sts w_sts;

    // Captured item
    logic                 r_neg;
    logic [MW-1:0]        r_mag;
    logic [DW-1:0]        r_decay;
    logic [FW-1:0]        r_fs0;

    // Output register
    logic                 r_out_valid;
    logic [LW-1:0]        r_out_low;
    logic [FW-1:0]        r_out_high;
    logic [FW-1:0]        r_out_coded;
    logic                 r_out_clamped;

    logic                 w_in_fire;
    logic                 w_out_free;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [FW-1:0]        w_quot;
    logic [lie_pkg::NUM_W-1:0] w_num;
    logic [lie_pkg::DEN_W-1:0] w_den;
    logic [FW-1:0]        w_fl;
    logic [FW-1:0]        w_fs;
    logic [FW-1:0]        w_steps;
    logic [MW-1:0]        w_steps_ext;
    logic [FW-1:0]        w_lo;
    logic [FW-1:0]        w_hi;
    logic [FW-1:0]        w_in_value;
    logic [FW-1:0]        w_in_given;
    logic [FW-1:0]        w_given_sat;

    assign w_in_value  = s_axis_tdata[15:0];
    assign w_in_given  = s_axis_tdata[45:30];
    assign w_given_sat = (w_in_given > FW'(lie_pkg::TOTAL)) ? FW'(lie_pkg::TOTAL) : w_in_given;

    assign s_axis_tready = (r_state == lie_pkg::ST_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // Derived start: 32768*(16384-decay)/(16384+decay)
    assign w_num = {(DW+1)'(lie_pkg::ONE_Q14 - {18'd0, r_decay}), LW'(0)};
    assign w_den = lie_pkg::DEN_W'(lie_pkg::ONE_Q14 + {18'd0, r_decay});

    lie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    lie_walk u_walk (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_fs0   (r_fs0),
        .i_mag   (r_mag),
        .i_decay (r_decay),
        .o_sts   (w_sts),
        .o_fl    (w_fl),
        .o_fs    (w_fs),
        .o_steps (w_steps)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lie_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_div_start  = 1'b0;
        w_ctl        = '0;
        case (r_state)
            lie_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    n_state = s_axis_tuser ? lie_pkg::ST_LOAD : lie_pkg::ST_DIV_GO;
                end
            end
            lie_pkg::ST_DIV_GO: begin
                w_div_start = 1'b1;
                n_state     = lie_pkg::ST_DIV_WAIT;
            end
            lie_pkg::ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = lie_pkg::ST_LOAD;
                end
            end
            lie_pkg::ST_LOAD: begin
                w_ctl.load = 1'b1;
                n_state    = lie_pkg::ST_MUL;
            end
            lie_pkg::ST_MUL: begin
                // stop once the requested magnitude is reached
                if (w_sts.at_mag) begin
                    n_state = lie_pkg::ST_FINISH;
                end else begin
                    w_ctl.mul_en = 1'b1;
                    n_state      = lie_pkg::ST_STEP;
                end
            end
            lie_pkg::ST_STEP: begin
                w_ctl.step_en = 1'b1;
                n_state = w_sts.fits ? lie_pkg::ST_MUL : lie_pkg::ST_FINISH;
            end
            lie_pkg::ST_FINISH: begin
                // hold until the output register can take the result
                if (w_out_free) begin
                    n_state = lie_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lie_pkg::ST_IDLE;
            end
        endcase
    end

    // Capture the item; the start frequency comes either from the input or
    // from the divider, made even.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_neg   <= w_in_value[FW-1];
            r_mag   <= w_in_value[FW-1] ? MW'(17'h10000 - {1'b0, w_in_value})
                                        : {1'b0, w_in_value};
            r_decay <= s_axis_tdata[29:16];
            r_fs0   <= w_given_sat;
        end else if ((r_state == lie_pkg::ST_DIV_WAIT) && w_div_done) begin
            r_fs0 <= {w_quot[FW-1:1], 1'b0};
        end
    end

    // Result: negative sign takes the upper slot of the pair.
    assign w_lo        = w_fl + (r_neg ? w_fs : FW'(0));
    assign w_hi        = w_lo + w_fs;
    assign w_steps_ext = {1'b0, w_steps};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == lie_pkg::ST_FINISH) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == lie_pkg::ST_FINISH) && w_out_free) begin
            r_out_clamped <= (w_steps_ext < r_mag);
            if (w_steps == '0) begin
                // zero symbol, sign dropped
                r_out_low   <= '0;
                r_out_high  <= r_fs0;
                r_out_coded <= '0;
            end else begin
                r_out_low   <= w_lo[LW-1:0];
                r_out_high  <= w_hi;
                r_out_coded <= r_neg ? FW'(0 - w_steps) : w_steps;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_coded, r_out_high, r_out_low};
    assign m_axis_tuser  = r_out_clamped;

    `LIE_ASSERT_NXT(a_busy_after_accept, w_in_fire, !s_axis_tready, "ready after accept")
    `LIE_ASSERT_IMP(a_steps_bound, r_state == lie_pkg::ST_FINISH, w_steps_ext <= r_mag, "walk overran magnitude")
    `LIE_ASSERT_IMP(a_interval_order, r_out_valid, r_out_high >= {1'b0, r_out_low}, "interval inverted")
    `LIE_ASSERT_IMP(a_interval_total, r_out_valid, r_out_high <= FW'(lie_pkg::TOTAL), "interval past total")

endmodule

// ===== tb/laplace_interval_checker.sv =====
`timescale 1ns / 1ps

module laplace_interval_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    // [15:0] value, [29:16] decay, [45:30] start_freq, [47:46] zero
    input  logic [47:0] i_in_tdata,
    // [0] use_given_start
    input  logic        i_in_tuser,
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    // [14:0] interval_low, [30:15] interval_high, [46:31] coded_value, [47] zero
    input  logic [47:0] i_out_tdata,
    // [0] was_clamped
    input  logic        i_out_tuser,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [lie_pkg::LOW_W-1:0]   low;
        logic [lie_pkg::FREQ_W-1:0]  high;
        logic [lie_pkg::VALUE_W-1:0] coded;
        logic                        clamped;
    } t_interval;

    t_interval expected_intervals[$];

    // Walk the Laplace table out from zero until the magnitude is reached or the
    // next pair of slots no longer fits in the total.
    function automatic t_interval predict_interval(
        input logic [lie_pkg::VALUE_W-1:0] raw,
        input logic [lie_pkg::DECAY_W-1:0] decay,
        input logic [lie_pkg::FREQ_W-1:0]  given,
        input logic                        use_given
    );
        t_interval   r;
        logic        neg;
        logic        fits;
        int unsigned mag;
        int unsigned slot;
        int unsigned slot0;
        int unsigned next_slot;
        int unsigned steps;
        int unsigned lo;
        int unsigned coded;
        int          floor_pos;
        int          next_floor;

        neg = raw[lie_pkg::VALUE_W-1];
        mag = neg ? (32'h10000 - 32'(raw)) : 32'(raw);
        if (use_given)
            slot = (32'(given) > lie_pkg::TOTAL) ? lie_pkg::TOTAL : 32'(given);
        else
            slot = ((lie_pkg::TOTAL * (lie_pkg::ONE_Q14 - 32'(decay)))
                    / (lie_pkg::ONE_Q14 + 32'(decay))) & ~32'd1;
        slot0     = slot;
        floor_pos = -int'(slot);
        steps     = 0;
        fits      = 1'b1;
        while (fits && steps < mag) begin
            next_floor = floor_pos + 2 * int'(slot);
            next_slot  = (slot * 32'(decay)) >> lie_pkg::Q_SHIFT;
            if (next_slot == 0)
                next_slot = 1;
            if (next_floor + 2 * int'(next_slot) > int'(lie_pkg::TOTAL)) begin
                fits = 1'b0;
            end else begin
                floor_pos = next_floor;
                slot      = next_slot;
                steps++;
            end
        end

        if (steps == 0) begin
            r.low   = '0;
            r.high  = slot0[lie_pkg::FREQ_W-1:0];
            r.coded = '0;
        end else begin
            lo      = 32'(floor_pos) + (neg ? slot : 32'd0);
            coded   = neg ? (32'h10000 - steps) : steps;
            r.low   = lo[lie_pkg::LOW_W-1:0];
            r.high  = 16'(lo + slot);
            r.coded = coded[lie_pkg::VALUE_W-1:0];
        end
        r.clamped = (steps < mag);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_interval exp_item;
        int        errs;
        errs = 0;
        if (i_rst_n) begin
            if (i_out_tvalid && i_out_tready) begin
                if (expected_intervals.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tuser=%b",
                             $time, i_out_tdata, i_out_tuser);
                    errs++;
                end else begin
                    exp_item = expected_intervals.pop_front();
                    if (i_out_tdata[14:0] !== exp_item.low) begin
                        $display("%0t: interval_low expected %0d actual %0d",
                                 $time, exp_item.low, i_out_tdata[14:0]);
                        errs++;
                    end
                    if (i_out_tdata[30:15] !== exp_item.high) begin
                        $display("%0t: interval_high expected %0d actual %0d",
                                 $time, exp_item.high, i_out_tdata[30:15]);
                        errs++;
                    end
                    if (i_out_tdata[46:31] !== exp_item.coded) begin
                        $display("%0t: coded_value expected %0d actual %0d", $time,
                                 $signed(exp_item.coded), $signed(i_out_tdata[46:31]));
                        errs++;
                    end
                    if (i_out_tuser !== exp_item.clamped) begin
                        $display("%0t: was_clamped expected %b actual %b",
                                 $time, exp_item.clamped, i_out_tuser);
                        errs++;
                    end
                end
            end
            if (i_in_tvalid && i_in_tready)
                expected_intervals.push_back(predict_interval(i_in_tdata[15:0],
                    i_in_tdata[29:16], i_in_tdata[45:30], i_in_tuser));
        end
        o_fail_count <= o_fail_count + errs;
        o_pending    <= expected_intervals.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

// ===== tb/tb_laplace_interval_encode_unit.sv =====
`timescale 1ns / 1ps

module tb_laplace_interval_encode_unit;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [15:0] value, [29:16] decay, [45:30] start_freq, [47:46] zero
    logic [47:0] s_axis_tdata;
    // [0] use_given_start
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [14:0] interval_low, [30:15] interval_high, [46:31] coded_value, [47] zero
    logic [47:0] m_axis_tdata;
    // [0] was_clamped
    logic        m_axis_tuser;

    int          fail_count;
    int          pending;

    // High while both sides run without any idling.
    logic        calm;

    laplace_interval_encode_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    laplace_interval_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tuser  (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Pick an idle length: none while calm, else mostly none or short, now and then a long one.
    function automatic int idle_cycles();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drive one input transaction; entered and left at a falling edge.
    // Keep tvalid high across back-to-back transactions.
    task automatic send_item(
        input logic [15:0] value,
        input logic [13:0] decay,
        input logic [15:0] start,
        input logic        use_given
    );
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {2'b00, start, decay, value};
        s_axis_tuser  = use_given;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Build one random item. Keep most magnitudes small so the walk stays
    // short; every hundredth item takes a full-range value.
    task automatic send_random(input int idx);
        logic [15:0] value;
        logic [15:0] mag;
        logic [13:0] decay;
        logic [15:0] start;
        int          pick;
        pick = $urandom_range(0, 99);
        if (idx % 100 == 99)
            value = 16'($urandom);
        else begin
            mag   = (pick < 70) ? 16'($urandom_range(0, 32)) : 16'($urandom_range(0, 255));
            value = $urandom_range(0, 1) ? -mag : mag;
        end
        case ($urandom_range(0, 9))
            0: decay = 14'd0;
            1: decay = 14'd16383;
            2: decay = 14'($urandom_range(15000, 16383));
            default: decay = 14'($urandom_range(0, 16383));
        endcase
        case ($urandom_range(0, 5))
            0: start = 16'($urandom);
            1: start = 16'($urandom_range(0, 16));
            2: start = 16'($urandom_range(32760, 32768));
            default: start = 16'($urandom_range(0, 32768));
        endcase
        send_item(value, decay, start, 1'($urandom_range(0, 1)));
    endtask

    // Result side: alternate ready bursts with random stalls.
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            int stall;
            stall = idle_cycles();
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    end

    // Hard stop: well beyond the slowest legal run of this stimulus.
    initial begin
        #80_000_000;
        $display("** laplace_interval_encode_unit: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        calm          = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Derived start with no decay: zero owns the whole table, so any
        // nonzero value clamps to zero.
        send_item(16'd0, 14'd0, 16'd0, 1'b0);
        send_item(16'd1, 14'd0, 16'd0, 1'b0);
        send_item(-16'sd1, 14'd0, 16'd0, 1'b0);
        // Typical derived models, both signs.
        send_item(16'd0, 14'd8000, 16'd0, 1'b0);
        send_item(16'd1, 14'd8000, 16'd0, 1'b0);
        send_item(-16'sd1, 14'd8000, 16'd0, 1'b0);
        send_item(16'd5, 14'd12000, 16'd0, 1'b0);
        send_item(-16'sd5, 14'd12000, 16'd0, 1'b0);
        // Given start of zero: empty zero interval, unit slots after it.
        send_item(16'd0, 14'd10000, 16'd0, 1'b1);
        send_item(16'd3, 14'd10000, 16'd0, 1'b1);
        send_item(-16'sd3, 14'd10000, 16'd0, 1'b1);
        // Given start at or above the total; above it saturates.
        send_item(16'd2, 14'd5000, 16'hFFFF, 1'b1);
        send_item(-16'sd2, 14'd5000, 16'd32768, 1'b1);
        send_item(16'd1, 14'd5000, 16'd32769, 1'b1);
        // One pair just fits at the top of the table.
        send_item(16'd1, 14'd0, 16'd32766, 1'b1);
        send_item(-16'sd1, 14'd0, 16'd32766, 1'b1);
        // Maximum decay: derived start rounds down to zero.
        send_item(16'd7, 14'd16383, 16'd0, 1'b0);
        send_item(16'd0, 14'd16383, 16'd1, 1'b1);
        // Extreme magnitudes, including the most negative value.
        send_item(16'd32767, 14'd100, 16'd0, 1'b0);
        send_item(16'd32767, 14'd16383, 16'd2, 1'b1);
        send_item(16'h8000, 14'd16383, 16'd2, 1'b1);
        send_item(16'h8001, 14'd16383, 16'd0, 1'b0);
        send_item(16'h8000, 14'd0, 16'd0, 1'b0);

        for (int n = 0; n < 1100; n++) begin
            // Reshuffle the idling mode now and then.
            if (n % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_random(n);
        end
        s_axis_tvalid = 1'b0;
        calm          = 1'b0;

        // Drain, then allow a margin for any stray result.
        wait (pending == 0);
        repeat (100) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("** laplace_interval_encode_unit: PASSED **");
        else
            $display("** laplace_interval_encode_unit: FAILED **");
        $finish;
    end

endmodule
